FILE: rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants for the length-prefixed file deframer: the parse
// phase codes and the fixed field widths.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int BYTE_W = 8;
  localparam int SKIP_W = 16;

  typedef enum logic [2:0] {
    PH_SKIP     = 3'd0,
    PH_COUNT    = 3'd1,
    PH_META_LEN = 3'd2,
    PH_META     = 3'd3,
    PH_DATA_LEN = 3'd4,
    PH_DATA     = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  typedef enum logic {
    FILE_META = 1'b0,
    FILE_DATA = 1'b1
  } file_sel_t;

endpackage

FILE: rtl/length_prefixed_file_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_file_deframer
// A result is registered when its item is accepted and shows in the next
// cycle. One item per cycle while the output is not stalled, set by the
// single-pass phase and counter update. Reset (synchronous) returns to the
// header skip phase with an empty output register and a zero skip count.
// ----------------------------------------------------------------------------
module length_prefixed_file_deframer
  import lpfd_pkg::*;
#(
  parameter int LENGTH_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SKIP_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                has_byte,
  output logic [BYTE_W-1:0]   payload_byte,
  output logic                file_select,
  output logic                last_of_file,
  output logic                done_res
);

  localparam int LEN_W = BYTE_W * LENGTH_BYTES;
  localparam int CNT_W = (LEN_W > SKIP_W) ? LEN_W : SKIP_W;
  localparam int IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

  phase_t             phase;
  phase_t             phase_next;
  logic [CNT_W-1:0]   remaining_count;
  logic [CNT_W-1:0]   remaining_count_next;
  logic [BYTE_W-1:0]  file_count;
  logic [BYTE_W-1:0]  file_count_next;
  logic [LEN_W-1:0]   length_assembly;
  logic [LEN_W-1:0]   length_assembly_next;

  logic               in_fire;
  logic [CNT_W-1:0]   count_dec;
  logic [CNT_W-1:0]   idx_full;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   assembled;
  logic               count_is_one;
  logic               one_file;

  logic               res_has;
  logic [BYTE_W-1:0]  res_pay;
  logic               res_sel;
  logic               res_last;
  logic               res_done;

  assign in_ready     = !out_valid || out_ready;
  assign in_fire      = in_valid && in_ready;
  assign count_dec    = remaining_count - CNT_W'(1);
  assign count_is_one = (remaining_count == CNT_W'(1));
  assign one_file     = (file_count == BYTE_W'(1));
  assign idx_full     = CNT_W'(LENGTH_BYTES) - remaining_count;
  assign idx          = idx_full[IDX_W-1:0];

  // place the incoming length byte in its lane
  always_comb begin
    assembled = length_assembly;
    for (int i = 0; i < LENGTH_BYTES; i++) begin
      if (idx == IDX_W'(i)) begin
        assembled[i*BYTE_W +: BYTE_W] = length_assembly[i*BYTE_W +: BYTE_W] | data_byte;
      end
    end
  end

  // next state
  always_comb begin
    phase_next           = phase;
    remaining_count_next = remaining_count;
    file_count_next      = file_count;
    length_assembly_next = length_assembly;
    if (in_fire) begin
      case (phase)
        PH_SKIP: begin
          if (remaining_count != '0) begin
            remaining_count_next = count_dec;
            if (count_is_one) begin
              phase_next = PH_COUNT;
            end
          end else begin
            file_count_next      = data_byte;
            phase_next           = PH_META_LEN;
            remaining_count_next = CNT_W'(LENGTH_BYTES);
            length_assembly_next = '0;
          end
        end
        PH_COUNT: begin
          file_count_next      = data_byte;
          phase_next           = PH_META_LEN;
          remaining_count_next = CNT_W'(LENGTH_BYTES);
          length_assembly_next = '0;
        end
        PH_META_LEN, PH_DATA_LEN: begin
          length_assembly_next = assembled;
          remaining_count_next = count_dec;
          if (count_is_one) begin
            if (assembled == '0) begin
              if (phase == PH_META_LEN) begin
                phase_next           = PH_DATA_LEN;
                remaining_count_next = CNT_W'(LENGTH_BYTES);
                length_assembly_next = '0;
              end else begin
                phase_next = PH_DONE;
              end
            end else begin
              phase_next           = (phase == PH_META_LEN) ? PH_META : PH_DATA;
              remaining_count_next = CNT_W'(assembled);
            end
          end
        end
        PH_META: begin
          remaining_count_next = count_dec;
          if (count_is_one) begin
            phase_next           = PH_DATA_LEN;
            remaining_count_next = CNT_W'(LENGTH_BYTES);
            length_assembly_next = '0;
          end
        end
        PH_DATA: begin
          remaining_count_next = count_dec;
          if (count_is_one) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    // a skip length write restarts the header skip
    if (cfg_we && (phase == PH_SKIP)) begin
      remaining_count_next = CNT_W'(cfg_data);
    end
  end

  // result of the item in flight
  always_comb begin
    res_has  = 1'b0;
    res_pay  = '0;
    res_sel  = FILE_META;
    res_last = 1'b0;
    res_done = 1'b0;
    case (phase)
      PH_META_LEN: begin
        res_done = count_is_one && (assembled == '0) && one_file;
      end
      PH_DATA_LEN: begin
        res_done = count_is_one && (assembled == '0);
      end
      PH_META: begin
        res_has  = 1'b1;
        res_pay  = data_byte;
        res_last = count_is_one;
        res_done = count_is_one && one_file;
      end
      PH_DATA: begin
        res_has  = 1'b1;
        res_pay  = data_byte;
        res_sel  = FILE_DATA;
        res_last = count_is_one;
        res_done = count_is_one;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SKIP;
      remaining_count <= '0;
      file_count      <= '0;
      length_assembly <= '0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      remaining_count <= remaining_count_next;
      file_count      <= file_count_next;
      length_assembly <= length_assembly_next;
      if (in_fire) begin
        out_valid <= res_has || res_done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      has_byte     <= res_has;
      payload_byte <= res_pay;
      file_select  <= res_sel;
      last_of_file <= res_last;
      done_res     <= res_done;
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for length_prefixed_file_deframer. Each run walks one frame
// through the block: a header skip that is rewritten several times, the file
// count, both length fields and both files, then stray bytes after the end.
// The shape of the frame (empty, long or endless meta file, empty data file)
// is picked at random. A byte-level model of the parser predicts every
// result and a checker compares each accepted result against it, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfd_pkg::*;

  localparam int LEN_BYTES    = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_CAP    = 200;

  typedef struct packed {
    logic              has;
    logic [BYTE_W-1:0] payload;
    file_sel_t         sel;
    logic              last;
    logic              done;
  } file_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [SKIP_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              has_byte;
  logic [BYTE_W-1:0] payload_byte;
  logic              file_select;
  logic              last_of_file;
  logic              done_res;

  // parser model state
  phase_t            frame_ph = PH_SKIP;
  logic [63:0]       left = '0;
  logic [7:0]        nfiles = '0;
  logic [63:0]       len_acc = '0;

  file_item_t        file_items_due[$];
  file_item_t        want;
  logic [63:0]       meta_len;
  logic [63:0]       data_len;
  int                meta_sent;
  bit                calm = 1'b0;
  int                mismatches = 0;
  int                cycles = 0;

  length_prefixed_file_deframer #(
    .LENGTH_BYTES(LEN_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .has_byte(has_byte),
    .payload_byte(payload_byte),
    .file_select(file_select),
    .last_of_file(last_of_file),
    .done_res(done_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void open_length(input phase_t next_ph);
    frame_ph = next_ph;
    left = 64'(LEN_BYTES);
    len_acc = '0;
  endfunction

  // length fields arrive low byte first
  function automatic bit gather_length(input logic [BYTE_W-1:0] b);
    logic [63:0] pos;
    pos = 64'(LEN_BYTES) - left;
    len_acc |= 64'(b) << (8 * pos[2:0]);
    if (left != 0) left--;
    return left == 0;
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output file_item_t r);
    r = '0;
    case (frame_ph)
      PH_SKIP: begin
        if (left != 0) begin
          left--;
          if (left == 0) frame_ph = PH_COUNT;
        end else begin
          nfiles = b;
          open_length(PH_META_LEN);
        end
      end
      PH_COUNT: begin
        nfiles = b;
        open_length(PH_META_LEN);
      end
      PH_META_LEN: begin
        if (gather_length(b)) begin
          if (len_acc == 0) begin
            r.done = (nfiles == 8'd1);
            open_length(PH_DATA_LEN);
          end else begin
            frame_ph = PH_META;
            left = len_acc;
          end
        end
      end
      PH_META: begin
        r.has = 1'b1;
        r.payload = b;
        r.sel = FILE_META;
        if (left != 0) left--;
        if (left == 0) begin
          r.last = 1'b1;
          r.done = (nfiles == 8'd1);
          open_length(PH_DATA_LEN);
        end
      end
      PH_DATA_LEN: begin
        if (gather_length(b)) begin
          if (len_acc == 0) begin
            r.done = 1'b1;
            frame_ph = PH_DONE;
          end else begin
            frame_ph = PH_DATA;
            left = len_acc;
          end
        end
      end
      PH_DATA: begin
        r.has = 1'b1;
        r.payload = b;
        r.sel = FILE_DATA;
        if (left != 0) left--;
        if (left == 0) begin
          r.last = 1'b1;
          r.done = 1'b1;
          frame_ph = PH_DONE;
        end
      end
      default: ;
    endcase
    return r.has || r.done;
  endfunction

  // mostly short gaps, now and then a long one, none while calm
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    file_item_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (deframe_byte(b, r)) file_items_due.push_back(r);
  endtask

  task automatic wait_drained();
    while (file_items_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_skip(input logic [SKIP_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (frame_ph == PH_SKIP) left = 64'(value);
  endtask

  task automatic send_length(input logic [63:0] len);
    for (int i = 0; i < LEN_BYTES; i++) send_byte(len[8*i +: 8]);
  endtask

  // rewrites restart the skip; a zero write leaves the next item as the count
  task automatic test_skip_header();
    int final_skip;
    write_skip('1);
    repeat ($urandom_range(2, 6)) send_byte(8'($urandom));
    write_skip(SKIP_W'($urandom_range(1, 65534)));
    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    write_skip('0);
    final_skip = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
    if (final_skip != 0) begin
      write_skip(SKIP_W'(final_skip));
      repeat (final_skip) send_byte(8'($urandom));
    end
  endtask

  task automatic test_file_count();
    send_byte($urandom_range(0, 1) ? 8'd1 : 8'($urandom));
  endtask

  task automatic test_meta_length();
    send_length(meta_len);
  endtask

  task automatic test_meta_file();
    repeat (meta_sent) send_byte(8'($urandom));
  endtask

  task automatic test_data_length();
    send_length(data_len);
  endtask

  task automatic test_data_file();
    repeat (int'(data_len)) send_byte(8'($urandom));
  endtask

  // stray bytes after the end, with a register write that must not matter
  task automatic test_trailing_bytes();
    repeat ($urandom_range(20, 40)) send_byte(8'($urandom));
    write_skip(SKIP_W'($urandom));
    repeat ($urandom_range(5, 15)) send_byte(8'($urandom));
  endtask

  initial begin
    forever begin
      repeat ($urandom_range(40, 300)) @(posedge clk);
      calm <= ~calm;
    end
  end

  initial begin : sink_side
    int stall;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (file_items_due.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: item with none expected: has %0b byte %02h file %0b last %0b done %0b",
                   $time, has_byte, payload_byte, file_select, last_of_file, done_res);
      end else begin
        want = file_items_due.pop_front();
        if (has_byte !== want.has || payload_byte !== want.payload ||
            file_select !== want.sel || last_of_file !== want.last ||
            done_res !== want.done) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch: expected %0b %02h %0b %0b %0b, got %0b %02h %0b %0b %0b",
                     $time, want.has, want.payload, want.sel, want.last, want.done,
                     has_byte, payload_byte, file_select, last_of_file, done_res);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("length_prefixed_file_deframer regression: fail");
    $finish;
  end

  initial begin
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      // meta file that never ends
      meta_len = '1;
      meta_sent = 1000;
      data_len = 64'($urandom_range(1, 40));
    end else if (pick == 1) begin
      meta_len = '0;
      meta_sent = 0;
      data_len = 64'($urandom_range(900, 1100));
    end else if (pick == 2) begin
      meta_len = 64'($urandom_range(900, 1100));
      meta_sent = int'(meta_len);
      data_len = '0;
    end else begin
      meta_len = 64'($urandom_range(1, 200));
      meta_sent = int'(meta_len);
      data_len = 64'($urandom_range(800, 1000));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_skip_header();
    test_file_count();
    test_meta_length();
    test_meta_file();
    test_data_length();
    test_data_file();
    test_trailing_bytes();
    in_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0)
      $display("length_prefixed_file_deframer regression: pass");
    else
      $display("length_prefixed_file_deframer regression: fail");
    $finish;
  end

endmodule
